// ===== src/nunt_pkg.sv =====
// Shared constants, codes and types of the nearest unvisited neighbor table.
package nunt_pkg;

  localparam int MAX_NEIGHBORS = 16;
  localparam int CITY_COUNT    = 64;
  localparam int COORD_BITS    = 16;

  localparam int ID_W   = 6;
  localparam int IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int VIS_W  = (CITY_COUNT > 1) ? $clog2(CITY_COUNT) : 1;
  localparam int ABS_W  = COORD_BITS;
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int DSQ_W  = 2 * COORD_BITS + 2;
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_MARK  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_FOUND       = 2'd0,
    STAT_ALL_VISITED = 2'd1,
    STAT_EMPTY       = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_OWN_X  = 2'd0,
    REG_OWN_Y  = 2'd1,
    REG_OWN_ID = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] pos;
    logic [ID_W-1:0]  city;
    logic [DSQ_W-1:0] dsq;
  } ins_t;

endpackage

// ===== src/nunt_table.sv =====
// Sorted neighbor entries with a parallel insert shift and one read port.
module nunt_table import nunt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  ins_t             ins_i,
  output logic [ID_W-1:0]  rd_city_o,
  output logic [DSQ_W-1:0] rd_dsq_o,
  output logic [CNT_W-1:0] count_o
);

  logic [ID_W-1:0]  city_q [MAX_NEIGHBORS];
  logic [DSQ_W-1:0] dsq_q  [MAX_NEIGHBORS];
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] last;
  logic             full;

  assign full      = (count_q == CNT_W'(MAX_NEIGHBORS));
  assign last      = full ? CNT_W'(MAX_NEIGHBORS - 1) : count_q;
  assign rd_city_o = city_q[rd_idx_i];
  assign rd_dsq_o  = dsq_q[rd_idx_i];
  assign count_o   = count_q;

  always_ff @(posedge clk_i) begin
    if (ins_i.valid) begin
      for (int k = 0; k < MAX_NEIGHBORS; k++) begin
        if (CNT_W'(k) == ins_i.pos) begin
          city_q[k] <= ins_i.city;
          dsq_q[k]  <= ins_i.dsq;
        end else if (k > 0 && CNT_W'(k) > ins_i.pos && CNT_W'(k) <= last) begin
          city_q[k] <= city_q[(k > 0) ? k - 1 : 0];
          dsq_q[k]  <= dsq_q[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ins_i.valid && !full) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

endmodule

// ===== src/nunt_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
module nunt_sqrt import nunt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DSQ_W-1:0]  rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int SCNT_W = $clog2(ROOT_W + 1);

  logic [DSQ_W-1:0]  n_q;
  logic [ROOT_W+1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign rem_sh = {rem_q[ROOT_W-1:0], n_q[DSQ_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign busy_o = busy_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= SCNT_W'(ROOT_W);
      n_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= n_q << 2;
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
      cnt_q  <= cnt_q - SCNT_W'(1);
      if (cnt_q == SCNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/nearest_unvisited_neighbor_table.sv =====
// Top level: config port, sequencer, shared squarer, visited bitmap and result register.
//
// Keeps one city's neighbors sorted by squared distance and a 64-bit visited
// bitmap. One item is in work at a time; in_ready_o is high only while the
// sequencer is idle. A mark, an ignored add or an unknown action is done in
// the idle state. An add squares dx then dy on the single squarer, then scans
// the entries in a one-entry-per-cycle position scan to find its slot; the
// insert shift itself is done in parallel. A query scans the entries in order
// to find an unvisited neighbor, then runs the bit-serial square root when
// one is found. The result register frees the input side while a result
// waits to be taken.
module nearest_unvisited_neighbor_table import nunt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             action_i,
  input  logic [ID_W-1:0]        city_id_i,
  input  logic signed [COORD_BITS-1:0] city_x_i,
  input  logic signed [COORD_BITS-1:0] city_y_i,
  input  logic                   visit_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             query_status_o,
  output logic [ID_W-1:0]        neighbor_id_o,
  output logic [ROOT_W-1:0]      neighbor_distance_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_X,
    S_SQ_Y,
    S_ADD_SCAN,
    S_Q_SCAN,
    S_SQRT,
    S_RESULT
  } state_e;

  state_e                 state_q;
  logic [COORD_BITS-1:0]  own_x_q;
  logic [COORD_BITS-1:0]  own_y_q;
  logic [ID_W-1:0]        own_id_q;
  logic [ID_W-1:0]        id_q;
  logic [COORD_BITS-1:0]  x_q;
  logic [COORD_BITS-1:0]  y_q;
  logic [DSQ_W-1:0]       acc_q;
  logic [CNT_W-1:0]       idx_q;
  logic [CITY_COUNT-1:0]  vmap_q;
  logic [1:0]             res_status_q;
  logic [ID_W-1:0]        res_id_q;
  logic [ROOT_W-1:0]      res_dist_q;
  logic                   out_valid_q;
  logic [1:0]             out_status_q;
  logic [ID_W-1:0]        out_id_q;
  logic [ROOT_W-1:0]      out_dist_q;

  logic [COORD_BITS:0]    diff;
  logic [ABS_W-1:0]       mag;
  logic [PROD_W-1:0]      prod;
  logic [ID_W-1:0]        rd_city;
  logic [DSQ_W-1:0]       rd_dsq;
  logic [CNT_W-1:0]       count;
  logic                   rd_in_range;
  logic [VIS_W-1:0]       rd_vidx;
  logic                   rd_visited;
  logic                   in_in_range;
  logic [VIS_W-1:0]       in_vidx;
  logic                   scan_end;
  logic                   found;
  logic                   out_free;
  logic                   cfg_wr;
  logic [31:0]            rd_city_w;
  logic [31:0]            in_id_w;
  ins_t                   ins;
  logic                   sqrt_busy;
  logic [ROOT_W-1:0]      sqrt_root;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    prdata = '0;
    unique case (paddr[ADDR_W-1:2])
      REG_OWN_X:  prdata = DATA_W'({{(DATA_W-COORD_BITS){own_x_q[COORD_BITS-1]}}, own_x_q});
      REG_OWN_Y:  prdata = DATA_W'({{(DATA_W-COORD_BITS){own_y_q[COORD_BITS-1]}}, own_y_q});
      REG_OWN_ID: prdata = DATA_W'(own_id_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (state_q == S_SQ_X) begin
      diff = {x_q[COORD_BITS-1], x_q} - {own_x_q[COORD_BITS-1], own_x_q};
    end else begin
      diff = {y_q[COORD_BITS-1], y_q} - {own_y_q[COORD_BITS-1], own_y_q};
    end
    mag  = diff[COORD_BITS] ? ABS_W'(-diff) : ABS_W'(diff);
    prod = PROD_W'(mag) * PROD_W'(mag);
  end

  assign rd_city_w   = 32'(rd_city);
  assign rd_in_range = (rd_city_w < 32'(CITY_COUNT));
  assign rd_vidx     = rd_city_w[VIS_W-1:0];
  assign rd_visited  = rd_in_range && vmap_q[rd_vidx];
  assign in_id_w     = 32'(city_id_i);
  assign in_in_range = (in_id_w < 32'(CITY_COUNT));
  assign in_vidx     = in_id_w[VIS_W-1:0];
  assign scan_end    = (idx_q == count);
  assign found       = (state_q == S_Q_SCAN) && !scan_end && !rd_visited;

  always_comb begin
    ins.valid = (state_q == S_ADD_SCAN) && (scan_end || acc_q <= rd_dsq)
                && (idx_q != CNT_W'(MAX_NEIGHBORS));
    ins.pos   = idx_q;
    ins.city  = id_q;
    ins.dsq   = acc_q;
  end

  nunt_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx_q[IDX_W-1:0]),
    .ins_i     (ins),
    .rd_city_o (rd_city),
    .rd_dsq_o  (rd_dsq),
    .count_o   (count)
  );

  nunt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (found),
    .rad_i   (rd_dsq),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      own_x_q      <= '0;
      own_y_q      <= '0;
      own_id_q     <= '0;
      id_q         <= '0;
      x_q          <= '0;
      y_q          <= '0;
      acc_q        <= '0;
      idx_q        <= '0;
      vmap_q       <= '0;
      res_status_q <= '0;
      res_id_q     <= '0;
      res_dist_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_id_q     <= '0;
      out_dist_q   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[ADDR_W-1:2])
          REG_OWN_X:  own_x_q  <= pwdata[COORD_BITS-1:0];
          REG_OWN_Y:  own_y_q  <= pwdata[COORD_BITS-1:0];
          REG_OWN_ID: own_id_q <= pwdata[ID_W-1:0];
          default: ;
        endcase
      end

      out_valid_q <= ((state_q == S_RESULT) && out_free) || (out_valid_q && !out_ready_i);

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            id_q  <= city_id_i;
            x_q   <= city_x_i;
            y_q   <= city_y_i;
            idx_q <= '0;
            unique case (action_i)
              ACT_ADD: begin
                if (city_id_i != own_id_q) begin
                  state_q <= S_SQ_X;
                end
              end
              ACT_QUERY: begin
                res_id_q   <= '0;
                res_dist_q <= '0;
                if (count == '0) begin
                  res_status_q <= STAT_EMPTY;
                  state_q      <= S_RESULT;
                end else begin
                  state_q <= S_Q_SCAN;
                end
              end
              ACT_MARK: begin
                if (in_in_range) begin
                  vmap_q[in_vidx] <= visit_value_i;
                end
              end
              default: ;
            endcase
          end
        end
        S_SQ_X: begin
          acc_q   <= DSQ_W'(prod);
          state_q <= S_SQ_Y;
        end
        S_SQ_Y: begin
          acc_q   <= acc_q + DSQ_W'(prod);
          state_q <= S_ADD_SCAN;
        end
        S_ADD_SCAN: begin
          if (scan_end || acc_q <= rd_dsq) begin
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + CNT_W'(1);
          end
        end
        S_Q_SCAN: begin
          if (scan_end) begin
            res_status_q <= STAT_ALL_VISITED;
            state_q      <= S_RESULT;
          end else if (!rd_visited) begin
            if (rd_in_range) begin
              vmap_q[rd_vidx] <= 1'b1;
            end
            res_status_q <= STAT_FOUND;
            res_id_q     <= rd_city;
            state_q      <= S_SQRT;
          end else begin
            idx_q <= idx_q + CNT_W'(1);
          end
        end
        S_SQRT: begin
          if (!sqrt_busy) begin
            res_dist_q <= sqrt_root;
            state_q    <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_id_q     <= res_id_q;
            out_dist_q   <= res_dist_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign query_status_o      = out_status_q;
  assign neighbor_id_o       = out_id_q;
  assign neighbor_distance_o = out_dist_q;

endmodule
